// File: rtl/som_pkg.sv
// ----------------------------------------------------------------------------
// som_pkg
// Shared types, codes and constants of the self-organizing map training block.
// ----------------------------------------------------------------------------
`default_nettype none

package som_pkg;

  // map geometry defaults
  localparam int MAP_WIDTH_DEF = 8;
  localparam int MAP_ROWS_DEF  = 8;

  // field widths
  localparam int NUM_FEATURES = 4;
  localparam int FEAT_W       = 16;
  localparam int IDX_W        = 6;
  localparam int TIE_W        = 7;
  localparam int LABEL_W      = 2;
  localparam int CMD_W        = 2;
  localparam int LR_W         = 16;
  localparam int RAD_W        = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int DIST_W       = 34;
  localparam int TIE_MAX      = 127;
  localparam int RADIUS_RST   = 1;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [TIE_W-1:0]          tie_t;
  typedef logic [LABEL_W-1:0]        label_t;
  typedef logic signed [FEAT_W-1:0]  feat_t;
  typedef logic [RAD_W-1:0]          radius_t;
  typedef logic [LR_W-1:0]           rate_t;

  // item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_TRAIN = 2'd1,
    CMD_LABEL = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd1;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_SDRAIN,
    ST_LSCAN,
    ST_LDRAIN,
    ST_UPD,
    ST_UDRAIN,
    ST_FETCH,
    ST_LOAD
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic wr_direct;
    logic scan_rd;
    logic lbl_pass;
    logic upd_rd;
    logic res_rd;
    logic clr_wr;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic busy;
    logic out_full;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/som_if.sv
// ----------------------------------------------------------------------------
// som_if
// Handshake channels of the map block: input items, result items, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface som_in_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             cmd;
  logic [5:0]             node_index;
  logic signed [15:0]     feature_0;
  logic signed [15:0]     feature_1;
  logic signed [15:0]     feature_2;
  logic signed [15:0]     feature_3;
  logic [1:0]             class_label;
  modport source (output valid, cmd, node_index, feature_0, feature_1, feature_2,
                  feature_3, class_label, input ready);
  modport sink (input valid, cmd, node_index, feature_0, feature_1, feature_2,
                feature_3, class_label, output ready);
endinterface

interface som_out_if;
  logic                   valid;
  logic                   ready;
  logic [5:0]             winner_index;
  logic [6:0]             tie_count;
  logic signed [15:0]     weight_0;
  logic signed [15:0]     weight_1;
  logic signed [15:0]     weight_2;
  logic signed [15:0]     weight_3;
  logic [1:0]             neuron_label;
  modport source (output valid, winner_index, tie_count, weight_0, weight_1, weight_2,
                  weight_3, neuron_label, input ready);
  modport sink (input valid, winner_index, tie_count, weight_0, weight_1, weight_2,
                weight_3, neuron_label, output ready);
endinterface

interface som_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/som_ctrl.sv
// ----------------------------------------------------------------------------
// som_ctrl
// Sequencer: label clearing, direct write, winner scan, label pass, window update, readback.
// ----------------------------------------------------------------------------
`default_nettype none

module som_ctrl #(
  parameter int MAP_WIDTH = som_pkg::MAP_WIDTH_DEF,
  parameter int MAP_ROWS  = som_pkg::MAP_ROWS_DEF,
  localparam int N  = MAP_WIDTH * MAP_ROWS,
  localparam int AW = $clog2(N),
  localparam int CW = $clog2(MAP_WIDTH),
  localparam int RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_cmd,
  input  wire som_pkg::idx_t     in_index,
  input  wire som_pkg::label_t   in_class,
  input  wire som_pkg::radius_t  radius,
  input  wire som_pkg::dp_sts_t  sts,
  input  wire logic [AW-1:0]     win_addr,
  input  wire logic [CW-1:0]     win_col,
  input  wire logic [RW-1:0]     win_row,
  output som_pkg::ctl_cmd_t      ctl,
  output logic [AW-1:0]          addr,
  output logic [CW-1:0]          col,
  output logic [RW-1:0]          row
);

  som_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  som_pkg::cmd_t   op_r, op_nxt;
  som_pkg::idx_t   idx_r, idx_nxt;
  logic            cls_nz_r, cls_nz_nxt;
  logic [CW-1:0]   c0_r, c0_nxt, c1_r, c1_nxt;
  logic [RW-1:0]   r0_r, r0_nxt, r1_r, r1_nxt;

  logic [7:0] wc8, wr8, rad8, c0w, c1w, r0w, r1w;
  logic [AW-1:0] upd_addr;
  logic          scan_op;

  // window bounds around the winner, clipped per axis
  always_comb begin
    wc8  = 8'(win_col);
    wr8  = 8'(win_row);
    rad8 = 8'(radius);
    c0w  = (wc8 > rad8) ? wc8 - rad8 : 8'd0;
    c1w  = (wc8 + rad8 > 8'(MAP_WIDTH - 1)) ? 8'(MAP_WIDTH - 1) : wc8 + rad8;
    r0w  = (wr8 > rad8) ? wr8 - rad8 : 8'd0;
    r1w  = (wr8 + rad8 > 8'(MAP_ROWS - 1)) ? 8'(MAP_ROWS - 1) : wr8 + rad8;
  end

  assign upd_addr = AW'(32'(row_r) * MAP_WIDTH + 32'(col_r));
  assign scan_op  = (op_r == som_pkg::CMD_TRAIN) || (op_r == som_pkg::CMD_LABEL);

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= som_pkg::ST_CLEAR;
      cnt_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // item context and window
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    cls_nz_r <= cls_nz_nxt;
    c0_r     <= c0_nxt;
    c1_r     <= c1_nxt;
    r0_r     <= r0_nxt;
    r1_r     <= r1_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    cls_nz_nxt = cls_nz_r;
    c0_nxt     = c0_r;
    c1_nxt     = c1_r;
    r0_nxt     = r0_r;
    r1_nxt     = r1_r;
    ctl        = '0;
    addr       = cnt_r;
    col        = col_r;
    row        = row_r;
    in_ready   = (state_r == som_pkg::ST_IDLE);
    unique case (state_r)
      som_pkg::ST_CLEAR: begin
        ctl.clr_wr = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == AW'(N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = som_pkg::ST_IDLE;
        end
      end
      som_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctl.start  = 1'b1;
          op_nxt     = som_pkg::cmd_t'(in_cmd);
          idx_nxt    = in_index;
          cls_nz_nxt = (in_class != '0);
          cnt_nxt    = '0;
          col_nxt    = '0;
          row_nxt    = '0;
          unique case (som_pkg::cmd_t'(in_cmd))
            som_pkg::CMD_WRITE: state_nxt = som_pkg::ST_WRITE;
            som_pkg::CMD_READ:  state_nxt = som_pkg::ST_FETCH;
            default:            state_nxt = som_pkg::ST_SCAN;
          endcase
        end
      end
      som_pkg::ST_WRITE: begin
        ctl.wr_direct = 1'b1;
        state_nxt     = som_pkg::ST_FETCH;
      end
      som_pkg::ST_SCAN, som_pkg::ST_LSCAN: begin
        ctl.scan_rd  = 1'b1;
        ctl.lbl_pass = (state_r == som_pkg::ST_LSCAN);
        cnt_nxt      = cnt_r + 1'b1;
        if (col_r == CW'(MAP_WIDTH - 1)) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        if (cnt_r == AW'(N - 1)) begin
          state_nxt = (state_r == som_pkg::ST_LSCAN) ? som_pkg::ST_LDRAIN
                                                     : som_pkg::ST_SDRAIN;
        end
      end
      som_pkg::ST_SDRAIN: begin
        if (!sts.busy) begin
          if (op_r == som_pkg::CMD_TRAIN) begin
            c0_nxt    = CW'(c0w);
            c1_nxt    = CW'(c1w);
            r0_nxt    = RW'(r0w);
            r1_nxt    = RW'(r1w);
            col_nxt   = CW'(c0w);
            row_nxt   = RW'(r0w);
            state_nxt = som_pkg::ST_UPD;
          end else if (cls_nz_r) begin
            cnt_nxt   = '0;
            col_nxt   = '0;
            row_nxt   = '0;
            state_nxt = som_pkg::ST_LSCAN;
          end else begin
            state_nxt = som_pkg::ST_FETCH;
          end
        end
      end
      som_pkg::ST_LDRAIN, som_pkg::ST_UDRAIN: begin
        if (!sts.busy) state_nxt = som_pkg::ST_FETCH;
      end
      som_pkg::ST_UPD: begin
        ctl.upd_rd = 1'b1;
        addr       = upd_addr;
        if (col_r == c1_r) begin
          col_nxt = c0_r;
          row_nxt = row_r + 1'b1;
          if (row_r == r1_r) state_nxt = som_pkg::ST_UDRAIN;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      som_pkg::ST_FETCH: begin
        ctl.res_rd = 1'b1;
        addr       = scan_op ? win_addr : AW'(idx_r);
        state_nxt  = som_pkg::ST_LOAD;
      end
      som_pkg::ST_LOAD: begin
        if (!sts.out_full) begin
          ctl.load_out = 1'b1;
          state_nxt    = som_pkg::ST_IDLE;
        end
      end
      default: state_nxt = som_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/som_dpath.sv
// ----------------------------------------------------------------------------
// som_dpath
// Weight and label memories, distance pipeline, winner tracker, weight update
// pipeline and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module som_dpath #(
  parameter int MAP_WIDTH = som_pkg::MAP_WIDTH_DEF,
  parameter int MAP_ROWS  = som_pkg::MAP_ROWS_DEF,
  localparam int N  = MAP_WIDTH * MAP_ROWS,
  localparam int AW = $clog2(N),
  localparam int CW = $clog2(MAP_WIDTH),
  localparam int RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1,
  localparam int TW = $clog2(N + 1),
  localparam int NF = som_pkg::NUM_FEATURES,
  localparam int FW = som_pkg::FEAT_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire som_pkg::ctl_cmd_t ctl,
  input  wire logic [AW-1:0]     addr,
  input  wire logic [CW-1:0]     col,
  input  wire logic [RW-1:0]     row,
  input  wire logic [1:0]        in_cmd,
  input  wire som_pkg::idx_t     in_index,
  input  wire som_pkg::feat_t    in_feature_0,
  input  wire som_pkg::feat_t    in_feature_1,
  input  wire som_pkg::feat_t    in_feature_2,
  input  wire som_pkg::feat_t    in_feature_3,
  input  wire som_pkg::label_t   in_class,
  input  wire som_pkg::rate_t    learn_rate,
  output som_pkg::dp_sts_t       sts,
  output logic [AW-1:0]          win_addr,
  output logic [CW-1:0]          win_col,
  output logic [RW-1:0]          win_row,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output som_pkg::idx_t          out_winner_index,
  output som_pkg::tie_t          out_tie_count,
  output som_pkg::feat_t         out_weight_0,
  output som_pkg::feat_t         out_weight_1,
  output som_pkg::feat_t         out_weight_2,
  output som_pkg::feat_t         out_weight_3,
  output som_pkg::label_t        out_neuron_label
);

  // item context
  som_pkg::cmd_t   op_r;
  som_pkg::idx_t   idx_r;
  som_pkg::feat_t  x_r [NF];
  som_pkg::label_t cls_r;

  // memories
  logic [NF*FW-1:0] wmem_r [N];
  logic [NF*FW-1:0] rdata_r;
  som_pkg::label_t  lmem_r [N];
  som_pkg::label_t  lrdata_r;

  // pipeline
  logic          s1_scan_r, s1_lbl_r, s1_upd_r;
  logic [AW-1:0] s1_addr_r, s2_addr_r, s3_addr_r, u2_addr_r;
  logic [CW-1:0] s1_col_r, s2_col_r, s3_col_r;
  logic [RW-1:0] s1_row_r, s2_row_r, s3_row_r;
  logic          s2_v_r, s2_lbl_r, s3_v_r, s3_lbl_r, u2_v_r;
  logic [31:0]   sq_r [NF];
  logic [som_pkg::DIST_W-1:0] dist_r;
  logic signed [33:0] p_r [NF];
  som_pkg::feat_t     wd_r [NF];

  // winner tracker
  logic [som_pkg::DIST_W-1:0] best_r;
  logic [AW-1:0] win_addr_r;
  logic [CW-1:0] win_col_r;
  logic [RW-1:0] win_row_r;
  logic [TW-1:0] ties_r;

  // result register
  logic            out_valid_r;
  som_pkg::idx_t   o_win_r;
  som_pkg::tie_t   o_tie_r;
  som_pkg::feat_t  o_w_r [NF];
  som_pkg::label_t o_lbl_r;

  som_pkg::feat_t     w_cur [NF];
  logic signed [16:0] d [NF];
  logic signed [33:0] dsq [NF];
  logic [NF*FW-1:0]   wb;
  logic               idx_ok, scan_op, rd_en, lbl_hit;

  assign idx_ok  = 32'(idx_r) < N;
  assign scan_op = (op_r == som_pkg::CMD_TRAIN) || (op_r == som_pkg::CMD_LABEL);
  assign rd_en   = ctl.scan_rd | ctl.upd_rd | ctl.res_rd;
  assign lbl_hit = s3_v_r && s3_lbl_r && (dist_r == best_r) && (cls_r != '0);

  // difference, square and gain products per feature
  always_comb begin
    for (int k = 0; k < NF; k++) begin
      w_cur[k] = rdata_r[k*FW +: FW];
      d[k]     = 17'(x_r[k]) - 17'(w_cur[k]);
      dsq[k]   = d[k] * d[k];
      wb[k*FW +: FW] = wd_r[k] + p_r[k][31:16];
    end
  end

  // capture item
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r  <= som_pkg::cmd_t'(in_cmd);
      idx_r <= in_index;
      x_r[0] <= in_feature_0;
      x_r[1] <= in_feature_1;
      x_r[2] <= in_feature_2;
      x_r[3] <= in_feature_3;
      cls_r <= in_class;
    end
  end

  // weight memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_direct && idx_ok) begin
      wmem_r[AW'(idx_r)] <= {x_r[3], x_r[2], x_r[1], x_r[0]};
    end else if (u2_v_r) begin
      wmem_r[u2_addr_r] <= wb;
    end
    if (rd_en) rdata_r <= wmem_r[addr];
  end

  // label memory
  always_ff @(posedge clk) begin
    if (ctl.clr_wr) begin
      lmem_r[addr] <= '0;
    end else if (lbl_hit) begin
      lmem_r[s3_addr_r] <= cls_r;
    end
    if (ctl.res_rd) lrdata_r <= lmem_r[addr];
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_scan_r <= 1'b0;
      s1_upd_r  <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      u2_v_r    <= 1'b0;
    end else begin
      s1_scan_r <= ctl.scan_rd;
      s1_upd_r  <= ctl.upd_rd;
      s2_v_r    <= s1_scan_r;
      s3_v_r    <= s2_v_r;
      u2_v_r    <= s1_upd_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_lbl_r  <= ctl.lbl_pass;
    s1_addr_r <= addr;
    s1_col_r  <= col;
    s1_row_r  <= row;
    s2_lbl_r  <= s1_lbl_r;
    s2_addr_r <= s1_addr_r;
    s2_col_r  <= s1_col_r;
    s2_row_r  <= s1_row_r;
    s3_lbl_r  <= s2_lbl_r;
    s3_addr_r <= s2_addr_r;
    s3_col_r  <= s2_col_r;
    s3_row_r  <= s2_row_r;
    u2_addr_r <= s1_addr_r;
    for (int k = 0; k < NF; k++) begin
      sq_r[k] <= dsq[k][31:0];
      p_r[k]  <= $signed({18'd0, learn_rate}) * 34'(d[k]);
      wd_r[k] <= w_cur[k];
    end
    dist_r <= som_pkg::DIST_W'(sq_r[0]) + som_pkg::DIST_W'(sq_r[1])
            + som_pkg::DIST_W'(sq_r[2]) + som_pkg::DIST_W'(sq_r[3]);
  end

  // running minimum, first lowest index wins, count ties
  always_ff @(posedge clk) begin
    if (s3_v_r && !s3_lbl_r) begin
      if ((s3_addr_r == '0) || (dist_r < best_r)) begin
        best_r     <= dist_r;
        win_addr_r <= s3_addr_r;
        win_col_r  <= s3_col_r;
        win_row_r  <= s3_row_r;
        ties_r     <= TW'(1);
      end else if (dist_r == best_r) begin
        ties_r <= ties_r + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      o_win_r <= scan_op ? som_pkg::idx_t'(win_addr_r) : idx_r;
      if (!scan_op) o_tie_r <= '0;
      else if (32'(ties_r) > som_pkg::TIE_MAX) o_tie_r <= som_pkg::tie_t'(som_pkg::TIE_MAX);
      else o_tie_r <= som_pkg::tie_t'(ties_r);
      for (int k = 0; k < NF; k++) begin
        o_w_r[k] <= (scan_op || idx_ok) ? w_cur[k] : '0;
      end
      o_lbl_r <= (scan_op || idx_ok) ? lrdata_r : '0;
    end
  end

  assign sts.busy     = s1_scan_r | s1_upd_r | s2_v_r | s3_v_r | u2_v_r;
  assign sts.out_full = out_valid_r;
  assign win_addr     = win_addr_r;
  assign win_col      = win_col_r;
  assign win_row      = win_row_r;
  assign out_valid        = out_valid_r;
  assign out_winner_index = o_win_r;
  assign out_tie_count    = o_tie_r;
  assign out_weight_0     = o_w_r[0];
  assign out_weight_1     = o_w_r[1];
  assign out_weight_2     = o_w_r[2];
  assign out_weight_3     = o_w_r[3];
  assign out_neuron_label = o_lbl_r;

endmodule

`default_nettype wire

// File: rtl/som_bmu_search_and_update.sv
// ----------------------------------------------------------------------------
// som_bmu_search_and_update
// Self-organizing map: best-matching neuron search, window update, labeling.
// ----------------------------------------------------------------------------
// One item at a time; every item gives one result. With N = MAP_WIDTH *
// MAP_ROWS, the scan reads one neuron per cycle from the one read port of
// the weight memory, and a train item's update moves one window neuron per
// cycle through the same port (the clipped window holds at most 225 neurons
// for radius 7), so N and the window set how long an item takes. A label
// item with a nonzero class scans the map a second time for the label pass.
// After reset a clearing pass zeroes the label memory; no item is taken
// during it, configuration writes are. Weights are undefined until written.
// The result register lets the next item be accepted while a result waits
// to be taken.
`default_nettype none

module som_bmu_search_and_update #(
  parameter int MAP_WIDTH = som_pkg::MAP_WIDTH_DEF,
  parameter int MAP_ROWS  = som_pkg::MAP_ROWS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  som_in_if.sink    in_if,
  som_out_if.source out_if,
  som_cfg_if.sink   cfg_if
);

  localparam int N  = MAP_WIDTH * MAP_ROWS;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(MAP_WIDTH);
  localparam int RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  som_pkg::rate_t   learn_rate_r;
  som_pkg::radius_t radius_r;

  som_pkg::ctl_cmd_t ctl;
  som_pkg::dp_sts_t  sts;
  logic [AW-1:0] addr, win_addr;
  logic [CW-1:0] col, win_col;
  logic [RW-1:0] row, win_row;

  // configuration registers
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r <= '0;
      radius_r     <= som_pkg::radius_t'(som_pkg::RADIUS_RST);
    end else if (cfg_if.valid) begin
      if (cfg_if.index == som_pkg::CFG_LEARN_RATE) learn_rate_r <= cfg_if.data;
      if (cfg_if.index == som_pkg::CFG_RADIUS) radius_r <= cfg_if.data[som_pkg::RAD_W-1:0];
    end
  end

  som_ctrl #(.MAP_WIDTH(MAP_WIDTH), .MAP_ROWS(MAP_ROWS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_cmd   (in_if.cmd),
    .in_index (in_if.node_index),
    .in_class (in_if.class_label),
    .radius   (radius_r),
    .sts      (sts),
    .win_addr (win_addr),
    .win_col  (win_col),
    .win_row  (win_row),
    .ctl      (ctl),
    .addr     (addr),
    .col      (col),
    .row      (row)
  );

  som_dpath #(.MAP_WIDTH(MAP_WIDTH), .MAP_ROWS(MAP_ROWS)) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .addr             (addr),
    .col              (col),
    .row              (row),
    .in_cmd           (in_if.cmd),
    .in_index         (in_if.node_index),
    .in_feature_0     (in_if.feature_0),
    .in_feature_1     (in_if.feature_1),
    .in_feature_2     (in_if.feature_2),
    .in_feature_3     (in_if.feature_3),
    .in_class         (in_if.class_label),
    .learn_rate       (learn_rate_r),
    .sts              (sts),
    .win_addr         (win_addr),
    .win_col          (win_col),
    .win_row          (win_row),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_winner_index (out_if.winner_index),
    .out_tie_count    (out_if.tie_count),
    .out_weight_0     (out_if.weight_0),
    .out_weight_1     (out_if.weight_1),
    .out_weight_2     (out_if.weight_2),
    .out_weight_3     (out_if.weight_3),
    .out_neuron_label (out_if.neuron_label)
  );

endmodule

`default_nettype wire

// File: rtl/som_checker.sv
// ----------------------------------------------------------------------------
// som_checker
// Port-level checks of the map block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module som_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] out_tie_count
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tie_count))
    else $error("result dropped or changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // label clearing pass holds off items right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item taken during label clearing");

  // reset empties the result register
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind som_bmu_search_and_update som_checker u_som_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_tie_count (out_if.tie_count)
);

`default_nettype wire

// File: tb/som_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// som_tb_pkg
// Item types and the map behavior predictor used by the map block testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package som_tb_pkg;
  import som_pkg::*;

  localparam int MAP_W = MAP_WIDTH_DEF;
  localparam int MAP_R = MAP_ROWS_DEF;
  localparam int NEURONS = MAP_W * MAP_R;

  typedef struct {
    cmd_t   cmd;
    idx_t   nidx;
    feat_t  feat [NUM_FEATURES];
    label_t cls;
  } sample_item_t;

  typedef struct {
    idx_t   winner;
    tie_t   ties;
    feat_t  wgt [NUM_FEATURES];
    label_t lbl;
  } map_result_t;

  // predictor state: map contents and configuration
  feat_t   map_wgt [NEURONS][NUM_FEATURES];
  label_t  map_lbl [NEURONS];
  rate_t   gain;
  radius_t radius;

  function automatic void map_reset();
    for (int n = 0; n < NEURONS; n++) begin
      map_lbl[n] = '0;
      for (int k = 0; k < NUM_FEATURES; k++) map_wgt[n][k] = '0;
    end
    gain = '0;
    radius = radius_t'(RADIUS_RST);
  endfunction

  // weight move: arithmetic shift floors toward minus infinity
  function automatic feat_t nudge(feat_t w, feat_t x);
    longint p;
    p = longint'({1'b0, gain}) * (longint'(x) - longint'(w));
    return feat_t'(longint'(w) + (p >>> 16));
  endfunction

  function automatic map_result_t map_predict(sample_item_t it);
    map_result_t r;
    longint dists [NEURONS];
    longint best, d;
    int win, ties, wc, wr, c0, c1, r0, r1, t, rad;
    if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
      r.winner = it.nidx;
      r.ties = '0;
      if (it.cmd == CMD_WRITE) map_wgt[it.nidx] = it.feat;
      for (int k = 0; k < NUM_FEATURES; k++) r.wgt[k] = map_wgt[it.nidx][k];
      r.lbl = map_lbl[it.nidx];
      return r;
    end
    best = 0;
    win = 0;
    ties = 0;
    // winner search, lowest index on ties
    for (int n = 0; n < NEURONS; n++) begin
      dists[n] = 0;
      for (int k = 0; k < NUM_FEATURES; k++) begin
        d = longint'(it.feat[k]) - longint'(map_wgt[n][k]);
        dists[n] += d * d;
      end
      if (n == 0 || dists[n] < best) begin
        best = dists[n];
        win = n;
        ties = 1;
      end else if (dists[n] == best) ties++;
    end
    if (it.cmd == CMD_TRAIN) begin
      // signed window bounds, clipped per axis
      rad = int'(radius);
      wc = win % MAP_W;
      wr = win / MAP_W;
      c0 = (wc - rad < 0) ? 0 : wc - rad;
      c1 = (wc + rad > MAP_W - 1) ? MAP_W - 1 : wc + rad;
      r0 = (wr - rad < 0) ? 0 : wr - rad;
      r1 = (wr + rad > MAP_R - 1) ? MAP_R - 1 : wr + rad;
      for (int row = r0; row <= r1; row++)
        for (int col = c0; col <= c1; col++) begin
          t = row * MAP_W + col;
          for (int k = 0; k < NUM_FEATURES; k++)
            map_wgt[t][k] = nudge(map_wgt[t][k], it.feat[k]);
        end
    end else if (it.cls != 0) begin
      for (int n = 0; n < NEURONS; n++)
        if (dists[n] == best) map_lbl[n] = it.cls;
    end
    r.winner = idx_t'(win);
    r.ties = tie_t'((ties > TIE_MAX) ? TIE_MAX : ties);
    for (int k = 0; k < NUM_FEATURES; k++) r.wgt[k] = map_wgt[win][k];
    r.lbl = map_lbl[win];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the map block: directed table then random items of all commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import som_pkg::*;
  import som_tb_pkg::*;

  logic clk;
  logic rst_n;

  som_in_if  in_if ();
  som_out_if out_if ();
  som_cfg_if cfg_if ();

  som_bmu_search_and_update i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  // directed row: has_fixed marks a result typed in by hand
  typedef struct {
    sample_item_t it;
    bit           has_fixed;
    map_result_t  fixed;
  } dir_row_t;

  map_result_t expected_q [$];
  int          mismatches;
  int          results_seen;
  int          trains_sent;
  int          labels_sent;
  bit          rx_stall_mode;

  always #2 clk = ~clk;

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    map_result_t e;
    bit bad;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item");
        end else begin
          e = expected_q.pop_front();
          bad = (out_if.winner_index !== e.winner) || (out_if.tie_count !== e.ties)
              || (out_if.weight_0 !== e.wgt[0]) || (out_if.weight_1 !== e.wgt[1])
              || (out_if.weight_2 !== e.wgt[2]) || (out_if.weight_3 !== e.wgt[3])
              || (out_if.neuron_label !== e.lbl);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp win %0d ties %0d w %0d %0d %0d %0d lbl %0d",
                        " / got %0d %0d %0d %0d %0d %0d %0d"},
                       e.winner, e.ties, e.wgt[0], e.wgt[1], e.wgt[2], e.wgt[3], e.lbl,
                       out_if.winner_index, out_if.tie_count, out_if.weight_0,
                       out_if.weight_1, out_if.weight_2, out_if.weight_3,
                       out_if.neuron_label);
          end
        end
      end
      if (rx_stall_mode) out_if.ready <= ($urandom_range(0, 3) != 0);
      else out_if.ready <= 1'b1;
    end
  end

  // alternate between stalling and free-running receiver phases
  initial begin
    rx_stall_mode = 1'b0;
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk);
      rx_stall_mode = ~rx_stall_mode;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_LEARN_RATE) gain = rate_t'(data);
    else radius = radius_t'(data);
    @(posedge clk);
  endtask

  // send one item; the valid stays high across back-to-back items unless drop_after is set
  task automatic send_item(sample_item_t it, bit has_fixed, map_result_t fixed,
                           bit drop_after);
    map_result_t p;
    in_if.valid        <= 1'b1;
    in_if.cmd          <= it.cmd;
    in_if.node_index   <= it.nidx;
    in_if.feature_0    <= it.feat[0];
    in_if.feature_1    <= it.feat[1];
    in_if.feature_2    <= it.feat[2];
    in_if.feature_3    <= it.feat[3];
    in_if.class_label  <= it.cls;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    p = map_predict(it);
    expected_q.push_back(has_fixed ? fixed : p);
    if (it.cmd == CMD_TRAIN) trains_sent++;
    if (it.cmd == CMD_LABEL) labels_sent++;
    if (drop_after) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic sample_item_t mk(cmd_t c, int n, int f0, int f1, int f2, int f3,
                                      int cl);
    sample_item_t it;
    it.cmd = c;
    it.nidx = idx_t'(n);
    it.feat[0] = feat_t'(f0);
    it.feat[1] = feat_t'(f1);
    it.feat[2] = feat_t'(f2);
    it.feat[3] = feat_t'(f3);
    it.cls = label_t'(cl);
    return it;
  endfunction

  function automatic map_result_t fx(int w, int t, int f0, int f1, int f2, int f3,
                                     int l);
    map_result_t r;
    r.winner = idx_t'(w);
    r.ties = tie_t'(t);
    r.wgt[0] = feat_t'(f0);
    r.wgt[1] = feat_t'(f1);
    r.wgt[2] = feat_t'(f2);
    r.wgt[3] = feat_t'(f3);
    r.lbl = label_t'(l);
    return r;
  endfunction

  function automatic feat_t rnd_feat(int spread);
    if ($urandom_range(0, 9) == 0) return feat_t'($urandom());
    return feat_t'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // stimulus
  initial begin
    dir_row_t     dir [$];
    dir_row_t     row;
    sample_item_t it;
    map_result_t  none;
    int           burst;
    int           sent;
    int           ph;

    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_WRITE;
    in_if.node_index = '0;
    in_if.feature_0 = '0;
    in_if.feature_1 = '0;
    in_if.feature_2 = '0;
    in_if.feature_3 = '0;
    in_if.class_label = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_LEARN_RATE;
    cfg_if.data = '0;
    mismatches = 0;
    results_seen = 0;
    trains_sent = 0;
    labels_sent = 0;
    none = fx(0, 0, 0, 0, 0, 0, 0);
    map_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, all neurons written, then every command
    row.has_fixed = 1'b1;
    row.it = mk(CMD_WRITE, 0, -32768, 32767, -32768, 32767, 0);
    row.fixed = fx(0, 0, -32768, 32767, -32768, 32767, 0);
    dir.push_back(row);
    row.it = mk(CMD_WRITE, 63, 32767, -32768, 32767, -32768, 0);
    row.fixed = fx(63, 0, 32767, -32768, 32767, -32768, 0);
    dir.push_back(row);
    row.it = mk(CMD_READ, 0, 0, 0, 0, 0, 3);
    row.fixed = fx(0, 0, -32768, 32767, -32768, 32767, 0);
    dir.push_back(row);
    foreach (dir[i]) send_item(dir[i].it, dir[i].has_fixed, dir[i].fixed, 1'b1);
    dir.delete();
    // fill remaining neurons with zero so neurons 1 to 62 start tied
    for (int n = 1; n < 63; n++) send_item(mk(CMD_WRITE, n, 0, 0, 0, 0, 0), 0, none, 1);
    row.has_fixed = 1'b0;
    row.it = mk(CMD_LABEL, 0, 0, 0, 0, 0, 2);        // 62 zero neurons tie
    dir.push_back(row);
    row.it = mk(CMD_LABEL, 0, 0, 0, 0, 0, 0);        // class 0 keeps labels
    dir.push_back(row);
    row.it = mk(CMD_TRAIN, 0, 300, 300, 300, 300, 0); // gain 0, no motion
    dir.push_back(row);
    row.it = mk(CMD_READ, 5, 0, 0, 0, 0, 0);
    dir.push_back(row);
    row.it = mk(CMD_LABEL, 0, -32768, 32767, -32768, 32767, 1);
    dir.push_back(row);
    foreach (dir[i]) send_item(dir[i].it, 0, none, 1'b1);
    dir.delete();
    drain();
    cfg_write(CFG_LEARN_RATE, 16'hFFFF);
    cfg_write(CFG_RADIUS, 16'd7);
    row.it = mk(CMD_TRAIN, 0, -32768, -32768, -32768, -32768, 0);
    dir.push_back(row);
    row.it = mk(CMD_TRAIN, 0, 1000, -1000, 77, -5, 0);
    dir.push_back(row);
    row.it = mk(CMD_READ, 9, 0, 0, 0, 0, 0);
    dir.push_back(row);
    foreach (dir[i]) send_item(dir[i].it, 0, none, 1'b0);
    in_if.valid <= 1'b0;
    dir.delete();
    drain();
    cfg_write(CFG_RADIUS, 16'd0);
    cfg_write(CFG_LEARN_RATE, 16'd1);
    send_item(mk(CMD_TRAIN, 0, 32767, 32767, 32767, 32767, 0), 0, none, 1);
    send_item(mk(CMD_TRAIN, 0, -32768, 5, 5, 5, 0), 0, none, 1);
    drain();

    // random phases with different settings; weights are written by random write items
    sent = 0;
    ph = 0;
    while (sent < 1800) begin
      case (ph % 4)
        0: begin
          cfg_write(CFG_LEARN_RATE, 16'($urandom()));
          cfg_write(CFG_RADIUS, 16'($urandom()));
        end
        1: begin cfg_write(CFG_LEARN_RATE, 16'd0); cfg_write(CFG_RADIUS, 16'd7); end
        2: begin cfg_write(CFG_LEARN_RATE, 16'hFFFF); cfg_write(CFG_RADIUS, 16'd0); end
        default: begin
          cfg_write(CFG_LEARN_RATE, 16'($urandom_range(1000, 20000)));
          cfg_write(CFG_RADIUS, 16'($urandom_range(1, 3)));
        end
      endcase
      for (int b = 0; b < 300 && sent < 1800; ) begin
        burst = $urandom_range(1, 12);
        for (int j = 0; j < burst; j++) begin
          it.nidx = idx_t'($urandom());
          for (int k = 0; k < NUM_FEATURES; k++)
            it.feat[k] = rnd_feat((ph % 2) ? 200 : 8000);
          it.cls = label_t'($urandom());
          case ($urandom_range(0, 9))
            0, 1: it.cmd = CMD_WRITE;
            2, 3, 4, 5: it.cmd = CMD_TRAIN;
            6, 7: it.cmd = CMD_LABEL;
            default: it.cmd = CMD_READ;
          endcase
          send_item(it, 0, none, (j == burst - 1));
          b++;
          sent++;
        end
        if ($urandom_range(0, 1)) repeat ($urandom_range(1, 60)) @(posedge clk);
      end
      drain();
      ph++;
    end
    drain();

    $display("covered %0d results: %0d train and %0d label items over %0d settings",
             results_seen, trains_sent, labels_sent, ph + 3);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
